// ===== hw/rtl/qsu_pkg.sv =====
// Shared types, codes and helpers of the quoted string unescape decoder.
package qsu_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindDone   = 2'd1,
    KindBadU   = 2'd2,
    KindUnterm = 2'd3
  } kind_e;

  // Command queue depth and pointer width
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // One decoded command: up to three result items
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    kind_e           kind;
    logic            handed_back;
  } cmd_t;

  // Hex digit decode: bit 4 set means valid
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ===== hw/rtl/qsu_if.sv =====
// Channel interfaces of the quoted string unescape decoder.
interface qsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface qsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       handed_back;
  logic       last;

  modport source (output valid, output out_byte, output kind, output handed_back,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input handed_back,
                  input last, output ready);
endinterface

// ===== hw/rtl/qsu_front.sv =====
// Front end: accepts text bytes, tracks string state and builds result commands.
module qsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  qsu_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output qsu_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhIn   = 3'd1,
    PhEsc  = 3'd2,
    PhHex  = 3'd3,
    PhSq   = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  quote_q, quote_d;
  logic [11:0] cp_q, cp_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;

  logic        accept;
  logic [7:0]  c;
  logic [4:0]  hv;
  logic [15:0] cp_full;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.in_byte;
  assign hv         = qsu_pkg::hex_value(c);
  assign cp_full    = {cp_q, hv[3:0]};

  // Decode one byte into next state and a command
  always_comb begin
    phase_d   = phase_q;
    quote_d   = quote_q;
    cp_d      = cp_q;
    hex_cnt_d = hex_cnt_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    cmd_o.kind = qsu_pkg::KindData;
    if (accept) begin
      unique case (phase_q)
        PhIdle: begin
          if (c != qsu_pkg::ChNul) begin
            quote_d = c;
            phase_d = PhIn;
          end
        end
        PhIn: begin
          if (c == qsu_pkg::ChNul) begin
            push_o     = 1'b1;
            cmd_o.kind = qsu_pkg::KindUnterm;
            phase_d    = PhIdle;
            quote_d    = '0;
          end else if (c == quote_q) begin
            if (quote_q == qsu_pkg::ChSquote) begin
              phase_d = PhSq;
            end else begin
              push_o     = 1'b1;
              cmd_o.kind = qsu_pkg::KindDone;
              phase_d    = PhIdle;
              quote_d    = '0;
            end
          end else if (quote_q == qsu_pkg::ChDquote && c == qsu_pkg::ChBslash) begin
            phase_d = PhEsc;
          end else begin
            push_o         = 1'b1;
            cmd_o.bytes[0] = c;
          end
        end
        PhEsc: begin
          if (c == qsu_pkg::ChNul) begin
            push_o     = 1'b1;
            cmd_o.kind = qsu_pkg::KindUnterm;
            phase_d    = PhIdle;
            quote_d    = '0;
          end else if (c == qsu_pkg::ChU) begin
            cp_d      = '0;
            hex_cnt_d = '0;
            phase_d   = PhHex;
          end else begin
            push_o = 1'b1;
            unique case (c)
              qsu_pkg::ChN:    cmd_o.bytes[0] = qsu_pkg::ChLf;
              qsu_pkg::ChT:    cmd_o.bytes[0] = qsu_pkg::ChTab;
              qsu_pkg::ChR:    cmd_o.bytes[0] = qsu_pkg::ChCr;
              qsu_pkg::ChZero: cmd_o.bytes[0] = qsu_pkg::ChNul;
              default:         cmd_o.bytes[0] = c;
            endcase
            phase_d = PhIn;
          end
        end
        PhHex: begin
          if (!hv[4]) begin
            push_o     = 1'b1;
            cmd_o.kind = qsu_pkg::KindBadU;
            phase_d    = PhIdle;
            quote_d    = '0;
            cp_d       = '0;
            hex_cnt_d  = '0;
          end else if (hex_cnt_q == 2'd3) begin
            // Emit the code point as UTF-8
            push_o = 1'b1;
            if (cp_full <= 16'h007F) begin
              cmd_o.bytes[0] = cp_full[7:0];
            end else if (cp_full <= 16'h07FF) begin
              cmd_o.bytes[0] = 8'hC0 | {3'b000, cp_full[10:6]};
              cmd_o.bytes[1] = 8'h80 | {2'b00, cp_full[5:0]};
              cmd_o.last_idx = 2'd1;
            end else begin
              cmd_o.bytes[0] = 8'hE0 | {4'b0000, cp_full[15:12]};
              cmd_o.bytes[1] = 8'h80 | {2'b00, cp_full[11:6]};
              cmd_o.bytes[2] = 8'h80 | {2'b00, cp_full[5:0]};
              cmd_o.last_idx = 2'd2;
            end
            cp_d      = '0;
            hex_cnt_d = '0;
            phase_d   = PhIn;
          end else begin
            cp_d      = cp_full[11:0];
            hex_cnt_d = hex_cnt_q + 2'd1;
          end
        end
        PhSq: begin
          push_o = 1'b1;
          if (c == qsu_pkg::ChSquote) begin
            cmd_o.bytes[0] = qsu_pkg::ChSquote;
            phase_d        = PhIn;
          end else begin
            cmd_o.kind        = qsu_pkg::KindDone;
            cmd_o.handed_back = 1'b1;
            phase_d           = PhIdle;
            quote_d           = '0;
          end
        end
        default: begin
          phase_d   = PhIdle;
          quote_d   = '0;
          cp_d      = '0;
          hex_cnt_d = '0;
        end
      endcase
    end
  end

  // Hold string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      quote_q   <= '0;
      cp_q      <= '0;
      hex_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      quote_q   <= quote_d;
      cp_q      <= cp_d;
      hex_cnt_q <= hex_cnt_d;
    end
  end

endmodule

// ===== hw/rtl/qsu_queue.sv =====
// Short command queue between the front end and the output sequencer.
module qsu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qsu_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output qsu_pkg::cmd_t head_o
);

  qsu_pkg::cmd_t                mem_q [qsu_pkg::QDepth];
  logic [qsu_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [qsu_pkg::QCntW-1:0]    cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == qsu_pkg::QCntW'(qsu_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// ===== hw/rtl/qsu_back.sv =====
// Output sequencer: plays each queued command out as one to three result items.
module qsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  qsu_pkg::cmd_t head_i,
  output logic          pop_o,
  qsu_out_if.source     out_o
);

  logic [1:0] idx_q;
  logic       is_last;
  logic       xfer;

  assign is_last          = (idx_q == head_i.last_idx);
  assign out_o.valid      = !empty_i;
  assign out_o.out_byte   = head_i.bytes[idx_q];
  assign out_o.kind       = head_i.kind;
  assign out_o.handed_back = head_i.handed_back;
  assign out_o.last       = is_last;
  assign xfer             = out_o.valid && out_o.ready;
  assign pop_o            = xfer && is_last;

  // Step through the bytes of the head command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ===== hw/rtl/quoted_string_unescape_decoder.sv =====
// Top level of the quoted string unescape decoder.
//
//   Channel  Dir  Payload                                 Transaction when
//   in_i     in   in_byte[7:0]                            valid && ready
//   out_o    out  out_byte[7:0] kind[1:0] handed_back last valid && ready
//
// One text byte is taken per cycle while the two-entry command queue has room.
// A \u escape that expands to two or three UTF-8 bytes holds the output side
// until all its bytes are out; the queue takes one more command, after which the
// input stalls until the expansion drains.
// Results appear at the earliest in the cycle after the byte that causes them.
// Reset returns the string state to idle and empties the queue.
// Output stalls back up into the queue, and input stalls only when it is full.
module quoted_string_unescape_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  qsu_in_if.sink    in_i,
  qsu_out_if.source out_o
);

  logic          push, full, pop, empty;
  qsu_pkg::cmd_t cmd, head;

  qsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  qsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  qsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("push into full command queue");

  // Status results are single items
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind != qsu_pkg::KindData) |-> out_o.last)
    else $error("status result not marked last");

  // A handed-back byte only comes with a done result
  a_handback_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.handed_back |-> (out_o.kind == qsu_pkg::KindDone))
    else $error("handed_back on non-done result");

  // A push into an empty queue shows a result in the next cycle
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && empty |=> out_o.valid)
    else $error("queued command not presented");

endmodule
